>>> hw/rtl/wft_pkg.sv
`timescale 1ns / 1ps

package wft_pkg;

  localparam int QUAT_W      = 16;
  localparam int OFFS_W      = 32;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_INDEX_W = 3;

  // rotation matrix entries, Q7.28 with headroom for non-unit quaternions
  localparam int MAT_W    = 35;
  localparam int MAT_LO_W = 18;
  localparam int MAT_HI_W = MAT_W - MAT_LO_W;

  localparam int FRAC_SHIFT = 28;
  localparam int POLE_SHIFT = 12;
  localparam int NSTAGE     = 9;

  localparam logic signed [QUAT_W-1:0] QUAT_ONE = 16'sd16384;
  localparam logic signed [MAT_W-1:0]  MAT_ONE  = 35'sd268435456;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_QUAT_W,
    CFG_QUAT_X,
    CFG_QUAT_Y,
    CFG_QUAT_Z,
    CFG_OFFSET_X,
    CFG_OFFSET_Y,
    CFG_OFFSET_Z,
    CFG_POLE_ENABLE
  } cfg_reg_t;

endpackage

>>> hw/rtl/wrench_frame_transform.sv
`timescale 1ns / 1ps

// Channel   | Handshake           | Payload
// ----------+---------------------+-----------------------------------------
// input     | in_valid/in_ready   | force_x/y/z, torque_x/y/z
// output    | out_valid/out_ready | force_out_x/y/z, torque_out_x/y/z
// config    | cfg_write           | cfg_index, cfg_data
//
// One transaction per cycle through nine register stages while out_ready is
// high or the output is empty; the depth is set by the split multiplies,
// product assembly and the pole cross-product stages.
// rst clears all stage valids and loads the identity rotation, pole off.
// out_ready low with out_valid high freezes every stage and drops in_ready.
// The rotation matrix is a register rebuilt from the quaternion registers after a write.

module wrench_frame_transform
  import wft_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [CFG_INDEX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [VALUE_WIDTH-1:0] force_x,
  input  logic signed [VALUE_WIDTH-1:0] force_y,
  input  logic signed [VALUE_WIDTH-1:0] force_z,
  input  logic signed [VALUE_WIDTH-1:0] torque_x,
  input  logic signed [VALUE_WIDTH-1:0] torque_y,
  input  logic signed [VALUE_WIDTH-1:0] torque_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [VALUE_WIDTH-1:0] force_out_x,
  output logic signed [VALUE_WIDTH-1:0] force_out_y,
  output logic signed [VALUE_WIDTH-1:0] force_out_z,
  output logic signed [VALUE_WIDTH-1:0] torque_out_x,
  output logic signed [VALUE_WIDTH-1:0] torque_out_y,
  output logic signed [VALUE_WIDTH-1:0] torque_out_z
);

  localparam int VW      = VALUE_WIDTH;
  localparam int VL      = VW / 2;
  localparam int VH      = VW - VL;
  localparam int PP_W    = MAT_LO_W + 1 + VH;
  localparam int PROD_W  = MAT_W + VW;
  localparam int ACC_W   = VW + 48;
  localparam int SH_W    = ACC_W - FRAC_SHIFT;
  localparam int CP_W    = OFFS_W + 1 + VH;
  localparam int NEXT1 [3] = '{1, 2, 0};
  localparam int NEXT2 [3] = '{2, 0, 1};

  localparam logic signed [ACC_W-1:0] HALF   = ACC_W'(1) <<< (FRAC_SHIFT - 1);
  localparam logic signed [VW-1:0]    VAL_MAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0]    VAL_MIN = {1'b1, {(VW-1){1'b0}}};

  function automatic logic signed [VW-1:0] round_sat(input logic signed [ACC_W-1:0] a);
    logic signed [SH_W-1:0] s;
    logic [SH_W-VW:0]       top;
    s   = a[ACC_W-1:FRAC_SHIFT];
    top = s[SH_W-1:VW-1];
    if ((&top) || (~|top)) begin
      return s[VW-1:0];
    end else if (s[SH_W-1]) begin
      return VAL_MIN;
    end else begin
      return VAL_MAX;
    end
  endfunction

  // configuration registers
  logic signed [QUAT_W-1:0] quat_w, quat_x, quat_y, quat_z;
  logic signed [OFFS_W-1:0] offset [3];
  logic                     pole_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      quat_w      <= QUAT_ONE;
      quat_x      <= '0;
      quat_y      <= '0;
      quat_z      <= '0;
      offset[0]   <= '0;
      offset[1]   <= '0;
      offset[2]   <= '0;
      pole_enable <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        CFG_QUAT_W:      quat_w      <= cfg_data[QUAT_W-1:0];
        CFG_QUAT_X:      quat_x      <= cfg_data[QUAT_W-1:0];
        CFG_QUAT_Y:      quat_y      <= cfg_data[QUAT_W-1:0];
        CFG_QUAT_Z:      quat_z      <= cfg_data[QUAT_W-1:0];
        CFG_OFFSET_X:    offset[0]   <= cfg_data[OFFS_W-1:0];
        CFG_OFFSET_Y:    offset[1]   <= cfg_data[OFFS_W-1:0];
        CFG_OFFSET_Z:    offset[2]   <= cfg_data[OFFS_W-1:0];
        CFG_POLE_ENABLE: pole_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // rotation matrix, rebuilt every cycle from the quaternion
  logic signed [2*QUAT_W-1:0] p_xx, p_yy, p_zz, p_xy, p_xz, p_yz, p_wx, p_wy, p_wz;
  logic signed [MAT_W-1:0]    mat_next [9];
  logic signed [MAT_W-1:0]    mat [9];

  always_comb begin
    p_xx = (2*QUAT_W)'(quat_x) * (2*QUAT_W)'(quat_x);
    p_yy = (2*QUAT_W)'(quat_y) * (2*QUAT_W)'(quat_y);
    p_zz = (2*QUAT_W)'(quat_z) * (2*QUAT_W)'(quat_z);
    p_xy = (2*QUAT_W)'(quat_x) * (2*QUAT_W)'(quat_y);
    p_xz = (2*QUAT_W)'(quat_x) * (2*QUAT_W)'(quat_z);
    p_yz = (2*QUAT_W)'(quat_y) * (2*QUAT_W)'(quat_z);
    p_wx = (2*QUAT_W)'(quat_w) * (2*QUAT_W)'(quat_x);
    p_wy = (2*QUAT_W)'(quat_w) * (2*QUAT_W)'(quat_y);
    p_wz = (2*QUAT_W)'(quat_w) * (2*QUAT_W)'(quat_z);
    mat_next[0] = MAT_ONE - ((MAT_W'(p_yy) + MAT_W'(p_zz)) <<< 1);
    mat_next[1] = (MAT_W'(p_xy) - MAT_W'(p_wz)) <<< 1;
    mat_next[2] = (MAT_W'(p_xz) + MAT_W'(p_wy)) <<< 1;
    mat_next[3] = (MAT_W'(p_xy) + MAT_W'(p_wz)) <<< 1;
    mat_next[4] = MAT_ONE - ((MAT_W'(p_xx) + MAT_W'(p_zz)) <<< 1);
    mat_next[5] = (MAT_W'(p_yz) - MAT_W'(p_wx)) <<< 1;
    mat_next[6] = (MAT_W'(p_xz) - MAT_W'(p_wy)) <<< 1;
    mat_next[7] = (MAT_W'(p_yz) + MAT_W'(p_wx)) <<< 1;
    mat_next[8] = MAT_ONE - ((MAT_W'(p_xx) + MAT_W'(p_yy)) <<< 1);
  end

  always_ff @(posedge clk) begin
    mat <= mat_next;
  end

  // pipeline control
  logic [NSTAGE-1:0] vld;
  logic              en;

  assign en        = !vld[NSTAGE-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[NSTAGE-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NSTAGE-2:0], in_valid};
    end
  end

  // stage registers
  logic signed [VW-1:0]     s1_vec [6];
  logic signed [PP_W-1:0]   s2_pp [18][4];
  logic signed [PROD_W-1:0] s3_prod [18];
  logic signed [ACC_W-1:0]  s4_acc [6];
  logic signed [VW-1:0]     s5_fo [3];
  logic signed [ACC_W-1:0]  s5_tacc [3];
  logic signed [CP_W-1:0]   s6_cp [3][2][2];
  logic signed [VW-1:0]     s6_fo [3];
  logic signed [ACC_W-1:0]  s6_tacc [3];
  logic signed [ACC_W-1:0]  s7_cross [3];
  logic signed [VW-1:0]     s7_fo [3];
  logic signed [ACC_W-1:0]  s7_tacc [3];
  logic signed [ACC_W-1:0]  s8_tsum [3];
  logic signed [VW-1:0]     s8_fo [3];
  logic signed [VW-1:0]     out_fo [3];
  logic signed [VW-1:0]     out_to [3];

  logic signed [PP_W-1:0]   pp_next [18][4];
  logic signed [PROD_W-1:0] prod_next [18];
  logic signed [ACC_W-1:0]  acc_next [6];
  logic signed [CP_W-1:0]   cp_next [3][2][2];
  logic signed [ACC_W-1:0]  cross_next [3];

  // split multiplies: matrix entry and vector component each cut in two
  always_comb begin
    logic signed [MAT_HI_W-1:0] mh;
    logic signed [MAT_LO_W:0]   ml;
    logic signed [VH-1:0]       vh;
    logic signed [VL:0]         vl;
    for (int k = 0; k < 18; k++) begin
      mh = mat[k % 9][MAT_W-1:MAT_LO_W];
      ml = {1'b0, mat[k % 9][MAT_LO_W-1:0]};
      vh = s1_vec[(k / 9) * 3 + (k % 3)][VW-1:VL];
      vl = {1'b0, s1_vec[(k / 9) * 3 + (k % 3)][VL-1:0]};
      pp_next[k][0] = PP_W'(mh) * PP_W'(vh);
      pp_next[k][1] = PP_W'(mh) * PP_W'(vl);
      pp_next[k][2] = PP_W'(ml) * PP_W'(vh);
      pp_next[k][3] = PP_W'(ml) * PP_W'(vl);
    end
  end

  always_comb begin
    for (int k = 0; k < 18; k++) begin
      prod_next[k] = (PROD_W'(s2_pp[k][0]) <<< (MAT_LO_W + VL))
                   + (PROD_W'(s2_pp[k][1]) <<< MAT_LO_W)
                   + (PROD_W'(s2_pp[k][2]) <<< VL)
                   + PROD_W'(s2_pp[k][3]);
    end
  end

  always_comb begin
    for (int g = 0; g < 2; g++) begin
      for (int r = 0; r < 3; r++) begin
        acc_next[g*3+r] = ACC_W'(s3_prod[g*9+r*3])
                        + ACC_W'(s3_prod[g*9+r*3+1])
                        + ACC_W'(s3_prod[g*9+r*3+2])
                        + ((g == 0) ? HALF : '0);
      end
    end
  end

  // pole term: offset x rotated force, row r uses (r+1, r+2) and (r+2, r+1)
  always_comb begin
    logic signed [VH-1:0] bh;
    logic signed [VL:0]   bl;
    for (int r = 0; r < 3; r++) begin
      bh = s5_fo[NEXT2[r]][VW-1:VL];
      bl = {1'b0, s5_fo[NEXT2[r]][VL-1:0]};
      cp_next[r][0][0] = CP_W'(offset[NEXT1[r]]) * CP_W'(bh);
      cp_next[r][0][1] = CP_W'(offset[NEXT1[r]]) * CP_W'(bl);
      bh = s5_fo[NEXT1[r]][VW-1:VL];
      bl = {1'b0, s5_fo[NEXT1[r]][VL-1:0]};
      cp_next[r][1][0] = CP_W'(offset[NEXT2[r]]) * CP_W'(bh);
      cp_next[r][1][1] = CP_W'(offset[NEXT2[r]]) * CP_W'(bl);
      if (!pole_enable) begin
        cp_next[r][0][0] = '0;
        cp_next[r][0][1] = '0;
        cp_next[r][1][0] = '0;
        cp_next[r][1][1] = '0;
      end
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      cross_next[r] = (ACC_W'(s6_cp[r][0][0]) <<< VL) + ACC_W'(s6_cp[r][0][1])
                    - (ACC_W'(s6_cp[r][1][0]) <<< VL) - ACC_W'(s6_cp[r][1][1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_vec[0] <= force_x;
      s1_vec[1] <= force_y;
      s1_vec[2] <= force_z;
      s1_vec[3] <= torque_x;
      s1_vec[4] <= torque_y;
      s1_vec[5] <= torque_z;
      s2_pp     <= pp_next;
      s3_prod   <= prod_next;
      s4_acc    <= acc_next;
      for (int r = 0; r < 3; r++) begin
        s5_fo[r]    <= round_sat(s4_acc[r]);
        s5_tacc[r]  <= s4_acc[3+r];
        s6_fo[r]    <= s5_fo[r];
        s6_tacc[r]  <= s5_tacc[r];
        s7_fo[r]    <= s6_fo[r];
        s7_tacc[r]  <= s6_tacc[r];
        s7_cross[r] <= cross_next[r];
        s8_fo[r]    <= s7_fo[r];
        s8_tsum[r]  <= s7_tacc[r] + (s7_cross[r] <<< POLE_SHIFT) + HALF;
        out_fo[r]   <= s8_fo[r];
        out_to[r]   <= round_sat(s8_tsum[r]);
      end
      s6_cp <= cp_next;
    end
  end

  assign force_out_x  = out_fo[0];
  assign force_out_y  = out_fo[1];
  assign force_out_z  = out_fo[2];
  assign torque_out_x = out_to[0];
  assign torque_out_y = out_to[1];
  assign torque_out_z = out_to[2];

  // identity quaternion gives the unit matrix in the cycle after
  a_identity_matrix : assert property (@(posedge clk) disable iff (rst)
    (quat_w == QUAT_ONE && quat_x == '0 && quat_y == '0 && quat_z == '0) |=>
    (mat[0] == MAT_ONE && mat[4] == MAT_ONE && mat[8] == MAT_ONE &&
     mat[1] == '0 && mat[5] == '0 && mat[6] == '0))
    else $error("rotation matrix not identity for identity quaternion");

  // a stalled output freezes the whole pipe
  a_stall_freeze : assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("stage valids moved during stall");

  // transactions advance one stage per enabled cycle, none created or lost
  a_valid_shift : assert property (@(posedge clk) disable iff (rst)
    (en && !$past(rst)) |=> vld[NSTAGE-1:1] == $past(vld[NSTAGE-2:0]))
    else $error("stage valids did not shift");

endmodule
